/* hdl/stpm_pkg.sv */
// ----------------------------------------------------------------------------
// Stereo pair matcher package
// Shared constants, status codes and the queue control types.
// ----------------------------------------------------------------------------
package stpm_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int TAG_BITS_DEF    = 32;
  localparam int QCNT_W          = 9;
  localparam logic [5:0] QUEUE_LIMIT_RST = 6'd30;

  localparam logic [2:0] ST_PUSHED     = 3'd0;
  localparam logic [2:0] ST_PUSH_DROP  = 3'd1;
  localparam logic [2:0] ST_EMPTY      = 3'd2;
  localparam logic [2:0] ST_LEFT_DROP  = 3'd3;
  localparam logic [2:0] ST_RIGHT_DROP = 3'd4;
  localparam logic [2:0] ST_PAIR       = 3'd5;

  localparam logic CFG_MAX_GAP = 1'b0;
  localparam logic CFG_LIMIT   = 1'b1;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic CAM_LEFT  = 1'b0;

  typedef enum logic [2:0] {
    Q_HOLD,
    Q_SHIFT,
    Q_ROT,
    Q_LOAD,
    Q_TRIM
  } q_op_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_NEXT,
    CELL_FRONT,
    CELL_NEW
  } cell_op_t;

  typedef struct packed {
    q_op_t              op;
    logic [QCNT_W-1:0]  trim_count;
  } q_ctrl_t;

endpackage

/* hdl/stpm_cell.sv */
// ----------------------------------------------------------------------------
// Queue cell
// Holds one frame entry and takes its neighbor, the front or a new entry.
// ----------------------------------------------------------------------------
module stpm_cell #(
  parameter int SB = 32
) (
  input  logic                 clk,
  input  stpm_pkg::cell_op_t   op,
  input  logic [63:0]          next_time,
  input  logic [SB-1:0]        next_tag,
  input  logic [63:0]          front_time,
  input  logic [SB-1:0]        front_tag,
  input  logic [63:0]          new_time,
  input  logic [SB-1:0]        new_tag,
  output logic [63:0]          time_q,
  output logic [SB-1:0]        tag_q
);

  always_ff @(posedge clk) begin
    unique case (op)
      stpm_pkg::CELL_NEXT: begin
        time_q <= next_time;
        tag_q  <= next_tag;
      end
      stpm_pkg::CELL_FRONT: begin
        time_q <= front_time;
        tag_q  <= front_tag;
      end
      stpm_pkg::CELL_NEW: begin
        time_q <= new_time;
        tag_q  <= new_tag;
      end
      default: begin
        time_q <= time_q;
        tag_q  <= tag_q;
      end
    endcase
  end

endmodule

/* hdl/stpm_queue.sv */
// ----------------------------------------------------------------------------
// Frame queue
// A row of cells with the oldest entry in cell zero and an entry count.
// ----------------------------------------------------------------------------
module stpm_queue #(
  parameter int QUEUE_DEPTH = stpm_pkg::QUEUE_DEPTH_DEF,
  parameter int SB          = 32,
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  stpm_pkg::q_ctrl_t   ctrl,
  input  logic [63:0]         new_time,
  input  logic [SB-1:0]       new_tag,
  output logic [63:0]         front_time,
  output logic [SB-1:0]       front_tag,
  output logic [CW-1:0]       count
);

  logic [63:0]   cell_time [QUEUE_DEPTH];
  logic [SB-1:0] cell_tag  [QUEUE_DEPTH];

  assign front_time = cell_time[0];
  assign front_tag  = cell_tag[0];

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    stpm_pkg::cell_op_t cop;
    logic [63:0]        nt;
    logic [SB-1:0]      ng;

    if (k == QUEUE_DEPTH - 1) begin : g_end
      assign nt = cell_time[k];
      assign ng = cell_tag[k];
    end else begin : g_mid
      assign nt = cell_time[k+1];
      assign ng = cell_tag[k+1];
    end

    always_comb begin
      unique case (ctrl.op)
        stpm_pkg::Q_SHIFT, stpm_pkg::Q_TRIM: cop = stpm_pkg::CELL_NEXT;
        stpm_pkg::Q_ROT:
          cop = (CW'(k) == count - CW'(1)) ? stpm_pkg::CELL_FRONT : stpm_pkg::CELL_NEXT;
        stpm_pkg::Q_LOAD:
          cop = (CW'(k) == count) ? stpm_pkg::CELL_NEW : stpm_pkg::CELL_HOLD;
        default: cop = stpm_pkg::CELL_HOLD;
      endcase
    end

    stpm_cell #(.SB(SB)) u_cell (
      .clk        (clk),
      .op         (cop),
      .next_time  (nt),
      .next_tag   (ng),
      .front_time (cell_time[0]),
      .front_tag  (cell_tag[0]),
      .new_time   (new_time),
      .new_tag    (new_tag),
      .time_q     (cell_time[k]),
      .tag_q      (cell_tag[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (ctrl.op)
        stpm_pkg::Q_SHIFT: count <= count - CW'(1);
        stpm_pkg::Q_LOAD:  count <= count + CW'(1);
        stpm_pkg::Q_TRIM:  count <= ctrl.trim_count[CW-1:0];
        default:           count <= count;
      endcase
    end
  end

endmodule

/* hdl/stereo_timestamp_pair_matcher.sv */
// ----------------------------------------------------------------------------
// Stereo timestamp pair matcher
// Two frame queues built from cell rows, with a nearest-timestamp pair search.
// ----------------------------------------------------------------------------
// A push drops oldest entries one at a time while the queue is at its limit,
// then loads the new one. A pop makes one gap compare per cycle while the
// right row rotates past each left entry in turn.
// A new request is taken only once the previous one is finished.
// Reset empties both queues and restores the registers to gap 0, limit 30.
module stereo_timestamp_pair_matcher #(
  parameter int QUEUE_DEPTH = stpm_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = stpm_pkg::TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic        camera_select,
  input  logic [63:0] frame_time,
  input  logic [31:0] frame_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [63:0] left_time,
  output logic [31:0] left_tag,
  output logic [63:0] right_time,
  output logic [31:0] right_tag,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int SB = (TAG_BITS < 32) ? TAG_BITS : 32;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > 6) ? CW : 6;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DROP  = 8'b0000_0010,
    S_LOAD  = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_STEP  = 8'b0001_0000,
    S_TRIM  = 8'b0010_0000,
    S_FRONT = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [63:0] max_pair_gap;
  logic [5:0]  queue_limit;

  logic          cam_q;
  logic [63:0]   ftime_q;
  logic [SB-1:0] ftag_q;
  logic          dropped;
  logic [CW-1:0] i_cnt, j_cnt, best_j;
  logic [63:0]   best_gap, best_rt;
  logic [SB-1:0] best_rtag;

  logic [2:0]  res_status;
  logic [63:0] res_lt, res_rt;
  logic [31:0] res_lg, res_rg;

  stpm_pkg::q_ctrl_t lctrl, rctrl;
  logic [63:0]   lt, rt;
  logic [SB-1:0] lg, rg;
  logic [CW-1:0] lc, rc;

  stpm_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .SB(SB), .CW(CW)) u_left (
    .clk(clk), .rst(rst), .ctrl(lctrl), .new_time(ftime_q), .new_tag(ftag_q),
    .front_time(lt), .front_tag(lg), .count(lc)
  );

  stpm_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .SB(SB), .CW(CW)) u_right (
    .clk(clk), .rst(rst), .ctrl(rctrl), .new_time(ftime_q), .new_tag(ftag_q),
    .front_time(rt), .front_tag(rg), .count(rc)
  );

  logic [LW-1:0] lim;
  logic [CW-1:0] sel_count;
  logic          push_full, match, last_j, last_i;
  logic [64:0]   diff;
  logic [63:0]   gap;

  always_comb begin
    if (queue_limit == 6'd0) begin
      lim = LW'(1);
    end else if (LW'(queue_limit) > LW'(QUEUE_DEPTH)) begin
      lim = LW'(QUEUE_DEPTH);
    end else begin
      lim = LW'(queue_limit);
    end
  end

  assign sel_count = (cam_q == stpm_pkg::CAM_LEFT) ? lc : rc;
  assign push_full = LW'(sel_count) >= lim;
  assign diff      = {1'b0, rt} - {1'b0, lt};
  assign gap       = diff[64] ? (lt - rt) : diff[63:0];
  assign match     = best_gap <= max_pair_gap;
  assign last_j    = j_cnt == rc - CW'(1);
  assign last_i    = i_cnt == lc - CW'(1);

  always_comb begin
    lctrl = '{op: stpm_pkg::Q_HOLD, trim_count: '0};
    rctrl = '{op: stpm_pkg::Q_HOLD, trim_count: '0};
    unique case (state)
      S_DROP: begin
        if (push_full) begin
          if (cam_q == stpm_pkg::CAM_LEFT) lctrl.op = stpm_pkg::Q_SHIFT;
          else rctrl.op = stpm_pkg::Q_SHIFT;
        end
      end
      S_LOAD: begin
        if (cam_q == stpm_pkg::CAM_LEFT) lctrl.op = stpm_pkg::Q_LOAD;
        else rctrl.op = stpm_pkg::Q_LOAD;
      end
      S_SCAN: rctrl.op = stpm_pkg::Q_ROT;
      S_STEP: begin
        if (match) begin
          lctrl.op         = stpm_pkg::Q_TRIM;
          lctrl.trim_count = stpm_pkg::QCNT_W'(lc - CW'(1) - i_cnt);
        end else begin
          lctrl.op = stpm_pkg::Q_ROT;
        end
      end
      S_TRIM: rctrl.op = stpm_pkg::Q_SHIFT;
      S_FRONT: begin
        if (lt < rt) lctrl.op = stpm_pkg::Q_SHIFT;
        else rctrl.op = stpm_pkg::Q_SHIFT;
      end
      default: ;
    endcase
  end

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pair_gap <= '0;
      queue_limit  <= stpm_pkg::QUEUE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stpm_pkg::CFG_MAX_GAP: max_pair_gap <= cfg_data;
        stpm_pkg::CFG_LIMIT:   queue_limit  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cam_q      <= camera_select;
            ftime_q    <= frame_time;
            ftag_q     <= SB'(frame_tag);
            dropped    <= 1'b0;
            i_cnt      <= '0;
            j_cnt      <= '0;
            res_lt     <= '0;
            res_lg     <= '0;
            res_rt     <= '0;
            res_rg     <= '0;
            res_status <= stpm_pkg::ST_EMPTY;
            if (mode == stpm_pkg::MODE_PUSH) state <= S_DROP;
            else if (lc == '0 || rc == '0) state <= S_DONE;
            else state <= S_SCAN;
          end
        end
        S_DROP: begin
          if (push_full) dropped <= 1'b1;
          else state <= S_LOAD;
        end
        S_LOAD: begin
          res_status <= dropped ? stpm_pkg::ST_PUSH_DROP : stpm_pkg::ST_PUSHED;
          state      <= S_DONE;
        end
        S_SCAN: begin
          if (j_cnt == '0 || gap < best_gap) begin
            best_gap  <= gap;
            best_j    <= j_cnt;
            best_rt   <= rt;
            best_rtag <= rg;
          end
          j_cnt <= j_cnt + CW'(1);
          if (last_j) state <= S_STEP;
        end
        S_STEP: begin
          j_cnt <= '0;
          if (match) begin
            res_status <= stpm_pkg::ST_PAIR;
            res_lt     <= lt;
            res_lg     <= 32'(lg);
            res_rt     <= best_rt;
            res_rg     <= 32'(best_rtag);
            state      <= S_TRIM;
          end else begin
            i_cnt <= i_cnt + CW'(1);
            state <= last_i ? S_FRONT : S_SCAN;
          end
        end
        S_TRIM: begin
          j_cnt <= j_cnt + CW'(1);
          if (j_cnt == best_j) state <= S_DONE;
        end
        S_FRONT: begin
          res_status <= (lt < rt) ? stpm_pkg::ST_LEFT_DROP : stpm_pkg::ST_RIGHT_DROP;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            left_time  <= res_lt;
            left_tag   <= res_lg;
            right_time <= res_rt;
            right_tag  <= res_rg;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    lc <= CW'(QUEUE_DEPTH)) else $error("left queue count above depth");

  a_right_bound: assert property (@(posedge clk) disable iff (rst)
    rc <= CW'(QUEUE_DEPTH)) else $error("right queue count above depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_STEP) |-> (lc != '0 && rc != '0))
    else $error("pair search on an empty queue");

  a_push_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> (LW'(sel_count) < lim))
    else $error("push would exceed the queue limit");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Stereo timestamp pair matcher testbench
// Drives push and pop requests through the request handshake, keeps a
// shadow copy of both frame queues and the registers, and checks every
// result field by field against the predicted one. A directed part covers
// empty pops, a left front drop, the widest gap and queue limit edges, and
// random phases follow with varied registers and idle patterns.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic        mode;
    logic        cam;
    logic [63:0] ftime;
    logic [31:0] ftag;
  } frame_req_t;

  typedef struct {
    logic [2:0]  status;
    logic [63:0] left_time;
    logic [31:0] left_tag;
    logic [63:0] right_time;
    logic [31:0] right_tag;
  } pair_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = 1'b0;
  logic        camera_select = 1'b0;
  logic [63:0] frame_time = '0;
  logic [31:0] frame_tag = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [63:0] left_time;
  logic [31:0] left_tag;
  logic [63:0] right_time;
  logic [31:0] right_tag;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;

  frame_req_t   frame_reqs[$];
  pair_result_t expected_results[$];
  frame_req_t   cur_req;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           mismatches = 0;
  logic [63:0]  time_base = 64'd1000;

  logic [63:0] shadow_time[2][32];
  logic [31:0] shadow_tag[2][32];
  int          shadow_head[2];
  int          shadow_count[2];
  logic [63:0] shadow_gap = '0;
  logic [5:0]  shadow_limit = stpm_pkg::QUEUE_LIMIT_RST;

  stereo_timestamp_pair_matcher u_top (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void predict_sync(input frame_req_t r);
    pair_result_t e;
    int lim, s, drop, ls, rs, best;
    logic [63:0] tl, g, best_gap;
    bit found;
    e = '{default: '0};
    found = 0;
    lim = (shadow_limit == 0) ? 1 : ((shadow_limit > 32) ? 32 : int'(shadow_limit));
    if (r.mode == stpm_pkg::MODE_PUSH) begin
      s = (r.cam == stpm_pkg::CAM_LEFT) ? 0 : 1;
      e.status = stpm_pkg::ST_PUSHED;
      if (shadow_count[s] + 1 > lim) begin
        drop = shadow_count[s] + 1 - lim;
        shadow_head[s] = (shadow_head[s] + drop) % 32;
        shadow_count[s] -= drop;
        e.status = stpm_pkg::ST_PUSH_DROP;
      end
      shadow_time[s][(shadow_head[s] + shadow_count[s]) % 32] = r.ftime;
      shadow_tag[s][(shadow_head[s] + shadow_count[s]) % 32] = r.ftag;
      shadow_count[s]++;
    end else if (shadow_count[0] == 0 || shadow_count[1] == 0) begin
      e.status = stpm_pkg::ST_EMPTY;
    end else begin
      for (int i = 0; i < shadow_count[0] && !found; i++) begin
        ls = (shadow_head[0] + i) % 32;
        tl = shadow_time[0][ls];
        best = 0;
        rs = shadow_head[1];
        best_gap = (shadow_time[1][rs] > tl) ? shadow_time[1][rs] - tl : tl - shadow_time[1][rs];
        for (int j = 1; j < shadow_count[1]; j++) begin
          rs = (shadow_head[1] + j) % 32;
          g = (shadow_time[1][rs] > tl) ? shadow_time[1][rs] - tl : tl - shadow_time[1][rs];
          if (g < best_gap) begin
            best_gap = g;
            best = j;
          end
        end
        if (best_gap <= shadow_gap) begin
          found = 1;
          rs = (shadow_head[1] + best) % 32;
          e.status = stpm_pkg::ST_PAIR;
          e.left_time = tl;
          e.left_tag = shadow_tag[0][ls];
          e.right_time = shadow_time[1][rs];
          e.right_tag = shadow_tag[1][rs];
          shadow_head[0] = (shadow_head[0] + i + 1) % 32;
          shadow_count[0] -= i + 1;
          shadow_head[1] = (shadow_head[1] + best + 1) % 32;
          shadow_count[1] -= best + 1;
        end
      end
      if (!found) begin
        if (shadow_time[0][shadow_head[0]] < shadow_time[1][shadow_head[1]]) begin
          shadow_head[0] = (shadow_head[0] + 1) % 32;
          shadow_count[0]--;
          e.status = stpm_pkg::ST_LEFT_DROP;
        end else begin
          shadow_head[1] = (shadow_head[1] + 1) % 32;
          shadow_count[1]--;
          e.status = stpm_pkg::ST_RIGHT_DROP;
        end
      end
    end
    expected_results.insert(expected_results.size(), e);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_sync(cur_req);
      end
      if (!in_valid || in_ready) begin
        if (frame_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = frame_reqs[0];
          frame_reqs.delete(0);
          in_valid <= 1'b1;
          mode <= cur_req.mode;
          camera_select <= cur_req.cam;
          frame_time <= cur_req.ftime;
          frame_tag <= cur_req.ftag;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    pair_result_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected result: status %0d", status);
          end
        end else begin
          e = expected_results[0];
          expected_results.delete(0);
          if (status !== e.status || left_time !== e.left_time || left_tag !== e.left_tag ||
              right_time !== e.right_time || right_tag !== e.right_tag) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected %0d %h %h %h %h, got %0d %h %h %h %h",
                       e.status, e.left_time, e.left_tag, e.right_time, e.right_tag,
                       status, left_time, left_tag, right_time, right_tag);
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_req(input logic m, input logic c, input logic [63:0] t,
                         input logic [31:0] g);
    frame_req_t req;
    req = '{mode: m, cam: c, ftime: t, ftag: g};
    frame_reqs.insert(frame_reqs.size(), req);
  endtask

  task automatic wait_drained();
    while (frame_reqs.size() > 0 || in_valid || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == stpm_pkg::CFG_MAX_GAP) begin
      shadow_gap = value;
    end else begin
      shadow_limit = value[5:0];
    end
  endtask

  task automatic add_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      time_base += $urandom_range(2000);
      if (r < 10) begin
        add_req(1'($urandom_range(1)), 1'($urandom_range(1)), {$urandom, $urandom},
                $urandom);
      end else if (r < 48) begin
        add_req(stpm_pkg::MODE_PUSH, stpm_pkg::CAM_LEFT, time_base + $urandom_range(3000),
                $urandom);
      end else if (r < 86) begin
        add_req(stpm_pkg::MODE_PUSH, ~stpm_pkg::CAM_LEFT, time_base + $urandom_range(3000),
                $urandom);
      end else begin
        add_req(~stpm_pkg::MODE_PUSH, 1'($urandom_range(1)), {$urandom, $urandom}, $urandom);
      end
    end
  endtask

  initial begin
    logic [63:0] gaps[4];
    logic [5:0]  limits[8];
    int          send_pcts[4];
    int          recv_pcts[4];
    gaps = '{64'd0, 64'd1500, '1, 64'd400};
    limits = '{6'd30, 6'd1, 6'd32, 6'd63, 6'd0, 6'd7, 6'd16, 6'd4};
    send_pcts = '{0, 61, 0, 8};
    recv_pcts = '{0, 0, 61, 8};
    for (int s = 0; s < 2; s++) begin
      shadow_head[s] = 0;
      shadow_count[s] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    add_req(~stpm_pkg::MODE_PUSH, 1'b0, '0, '0);
    add_req(stpm_pkg::MODE_PUSH, stpm_pkg::CAM_LEFT, 64'd100, 32'h0);
    add_req(~stpm_pkg::MODE_PUSH, 1'b1, '1, '1);
    add_req(stpm_pkg::MODE_PUSH, ~stpm_pkg::CAM_LEFT, 64'd100, '1);
    add_req(~stpm_pkg::MODE_PUSH, 1'b0, '0, '0);
    add_req(stpm_pkg::MODE_PUSH, stpm_pkg::CAM_LEFT, 64'd10, 32'h1234);
    add_req(stpm_pkg::MODE_PUSH, ~stpm_pkg::CAM_LEFT, 64'd20, 32'h5678);
    add_req(~stpm_pkg::MODE_PUSH, 1'b0, '0, '0);
    add_req(~stpm_pkg::MODE_PUSH, 1'b0, '0, '0);
    add_req(stpm_pkg::MODE_PUSH, ~stpm_pkg::CAM_LEFT, 64'd7, 32'h77);
    add_req(stpm_pkg::MODE_PUSH, stpm_pkg::CAM_LEFT, 64'd9, 32'h99);
    add_req(~stpm_pkg::MODE_PUSH, 1'b0, '0, '0);
    add_req(stpm_pkg::MODE_PUSH, ~stpm_pkg::CAM_LEFT, '1, 32'hA5A5A5A5);
    add_req(stpm_pkg::MODE_PUSH, stpm_pkg::CAM_LEFT, 64'd0, 32'h5A5A5A5A);
    wait_drained();
    write_reg(stpm_pkg::CFG_MAX_GAP, '1);
    add_req(~stpm_pkg::MODE_PUSH, 1'b0, '0, '0);
    add_req(~stpm_pkg::MODE_PUSH, 1'b0, '0, '0);
    wait_drained();
    write_reg(stpm_pkg::CFG_LIMIT, 64'd0);
    add_req(stpm_pkg::MODE_PUSH, stpm_pkg::CAM_LEFT, 64'd5, 32'h1);
    add_req(stpm_pkg::MODE_PUSH, stpm_pkg::CAM_LEFT, 64'd6, 32'h2);
    wait_drained();
    write_reg(stpm_pkg::CFG_LIMIT, 64'd32);
    for (int i = 0; i < 5; i++) add_req(stpm_pkg::MODE_PUSH, stpm_pkg::CAM_LEFT, 64'd50 + i, i);
    wait_drained();
    write_reg(stpm_pkg::CFG_LIMIT, 64'd2);
    add_req(stpm_pkg::MODE_PUSH, stpm_pkg::CAM_LEFT, 64'd60, 32'h3);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      send_idle_pct = send_pcts[p % 4];
      recv_stall_pct = recv_pcts[p % 4];
      write_reg(stpm_pkg::CFG_MAX_GAP, (p == 7) ? {$urandom, $urandom} : gaps[p % 4]);
      write_reg(stpm_pkg::CFG_LIMIT, {58'd0, limits[p]});
      if (p == 2) begin
        add_random(30);
        wait_drained();
        add_random(30);
      end else begin
        add_random(65);
      end
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
